>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define VNSN_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define VNSN_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> design/vnsn_pkg.sv
// ----------------------------------------------------------------------------
// Vertex normal package
// Shared constants of the six-neighbour vertex normal pipeline.
// ----------------------------------------------------------------------------
package vnsn_pkg;

  // Default coordinate width and normal fraction width.
  localparam int DEF_COORD_BITS       = 16;
  localparam int DEF_NORMAL_FRAC_BITS = 14;

  // Fixed field widths.
  localparam int POS_BITS = 48;
  localparam int OUT_BITS = 16;

  // Summed components are cut down to this many bits before squaring.
  localparam int REDUCE_BITS = 24;

  // Extra fraction bits of the square root.
  localparam int SQRT_EXTRA = 6;

  // Width of the square root result.
  localparam int ROOT_BITS = REDUCE_BITS + 1 + SQRT_EXTRA;

endpackage

>>> design/vnsn_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Restoring digit recurrence, one root bit per register stage.
// ----------------------------------------------------------------------------
module vnsn_sqrt #(
  parameter int RW  = vnsn_pkg::ROOT_BITS,
  parameter int SBW = 1
) (
  input  logic              clk,
  input  logic [RW-1:0]     en,
  input  logic [2*RW-1:0]   rad,
  input  logic [SBW-1:0]    sb_in,
  output logic [RW-1:0]     root,
  output logic [SBW-1:0]    sb_out
);

  localparam int MW = RW + 2;

  logic [MW-1:0]   rem_q  [RW];
  logic [RW-1:0]   root_q [RW];
  logic [2*RW-1:0] rad_q  [RW];
  logic [SBW-1:0]  sb_q   [RW];

  for (genvar gi = 0; gi < RW; gi++) begin : g_stage
    logic [MW-1:0]   p_rem;
    logic [RW-1:0]   p_root;
    logic [2*RW-1:0] p_rad;
    logic [SBW-1:0]  p_sb;
    logic [MW-1:0]   cat;
    logic [MW-1:0]   trial;

    // Previous stage, or the pipeline input for the first one.
    if (gi == 0) begin : g_first
      assign p_rem  = '0;
      assign p_root = '0;
      assign p_rad  = rad;
      assign p_sb   = sb_in;
    end else begin : g_next
      assign p_rem  = rem_q[gi-1];
      assign p_root = root_q[gi-1];
      assign p_rad  = rad_q[gi-1];
      assign p_sb   = sb_q[gi-1];
    end

    // Bring down the next two radicand bits and try the next root bit.
    assign cat   = {p_rem[MW-3:0], p_rad[2*RW-1 -: 2]};
    assign trial = {p_root, 2'b01};

    always_ff @(posedge clk) begin
      if (en[gi]) begin
        if (cat >= trial) begin
          rem_q[gi]  <= cat - trial;
          root_q[gi] <= {p_root[RW-2:0], 1'b1};
        end else begin
          rem_q[gi]  <= cat;
          root_q[gi] <= {p_root[RW-2:0], 1'b0};
        end
        rad_q[gi] <= p_rad << 2;
        sb_q[gi]  <= p_sb;
      end
    end
  end

  assign root   = root_q[RW-1];
  assign sb_out = sb_q[RW-1];

endmodule

>>> design/vnsn_div.sv
// ----------------------------------------------------------------------------
// Pipelined three-lane divider
// Restoring division of three dividends by one shared divisor, one quotient
// bit per register stage.
// ----------------------------------------------------------------------------
module vnsn_div #(
  parameter int QB  = vnsn_pkg::DEF_NORMAL_FRAC_BITS + 2,
  parameter int NW  = vnsn_pkg::REDUCE_BITS + vnsn_pkg::DEF_NORMAL_FRAC_BITS + 7,
  parameter int RW  = vnsn_pkg::ROOT_BITS,
  parameter int SBW = 1
) (
  input  logic                  clk,
  input  logic [QB-1:0]         en,
  input  logic [2:0][NW-1:0]    num,
  input  logic [RW-1:0]         dvs,
  input  logic [SBW-1:0]        sb_in,
  output logic [2:0][QB-1:0]    quo,
  output logic [SBW-1:0]        sb_out
);

  logic [2:0][RW-1:0] rem_q [QB];
  logic [2:0][QB-1:0] low_q [QB];
  logic [2:0][QB-1:0] quo_q [QB];
  logic [RW-1:0]      dvs_q [QB];
  logic [SBW-1:0]     sb_q  [QB];

  for (genvar gi = 0; gi < QB; gi++) begin : g_stage
    logic [RW-1:0]  p_dvs;
    logic [SBW-1:0] p_sb;

    if (gi == 0) begin : g_first
      assign p_dvs = dvs;
      assign p_sb  = sb_in;
    end else begin : g_next
      assign p_dvs = dvs_q[gi-1];
      assign p_sb  = sb_q[gi-1];
    end

    // Divisor and side data move along with the lanes.
    always_ff @(posedge clk) begin
      if (en[gi]) begin
        dvs_q[gi] <= p_dvs;
        sb_q[gi]  <= p_sb;
      end
    end

    for (genvar gl = 0; gl < 3; gl++) begin : g_lane
      logic [RW-1:0] p_rem;
      logic [QB-1:0] p_low;
      logic [QB-1:0] p_quo;
      logic [RW:0]   cat;
      logic [RW:0]   dd;

      // The top dividend bits form the first partial remainder.
      if (gi == 0) begin : g_first
        assign p_rem = RW'(num[gl][NW-1:QB]);
        assign p_low = num[gl][QB-1:0];
        assign p_quo = '0;
      end else begin : g_next
        assign p_rem = rem_q[gi-1][gl];
        assign p_low = low_q[gi-1][gl];
        assign p_quo = quo_q[gi-1][gl];
      end

      assign cat = {p_rem, p_low[QB-1]};
      assign dd  = {1'b0, p_dvs};

      // Subtract when the divisor fits and record the quotient bit.
      always_ff @(posedge clk) begin
        if (en[gi]) begin
          if (cat >= dd) begin
            rem_q[gi][gl] <= RW'(cat - dd);
            quo_q[gi][gl] <= {p_quo[QB-2:0], 1'b1};
          end else begin
            rem_q[gi][gl] <= RW'(cat);
            quo_q[gi][gl] <= {p_quo[QB-2:0], 1'b0};
          end
          low_q[gi][gl] <= p_low << 1;
        end
      end
    end
  end

  assign quo    = quo_q[QB-1];
  assign sb_out = sb_q[QB-1];

endmodule

>>> design/vertex_normal_six_neighbours_core.sv
// ----------------------------------------------------------------------------
// Vertex normal from six grid neighbours
// Sums the six ring cross products of neighbour differences and normalizes
// the sum to signed Q1.NORMAL_FRAC_BITS.
// ----------------------------------------------------------------------------
// The core takes one transaction per clock unless a stalled output has filled
// the pipeline, and returns one result per transaction, in order. Its depth
// comes mostly from the square root, which resolves one root bit per stage,
// and the divider, which resolves one quotient bit per stage. A stalled
// output holds the pipeline only as far back as it is full, so empty stages
// keep taking new transactions.
`include "assert_macros.svh"

module vertex_normal_six_neighbours_core #(
  parameter int COORD_BITS       = vnsn_pkg::DEF_COORD_BITS,
  parameter int NORMAL_FRAC_BITS = vnsn_pkg::DEF_NORMAL_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [vnsn_pkg::POS_BITS-1:0]       center_pos,
  input  logic [vnsn_pkg::POS_BITS-1:0]       right_pos,
  input  logic [vnsn_pkg::POS_BITS-1:0]       down_pos,
  input  logic [vnsn_pkg::POS_BITS-1:0]       down_left_pos,
  input  logic [vnsn_pkg::POS_BITS-1:0]       left_pos,
  input  logic [vnsn_pkg::POS_BITS-1:0]       up_pos,
  input  logic [vnsn_pkg::POS_BITS-1:0]       up_right_pos,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [vnsn_pkg::OUT_BITS-1:0] normal_x,
  output logic signed [vnsn_pkg::OUT_BITS-1:0] normal_y,
  output logic signed [vnsn_pkg::OUT_BITS-1:0] normal_z,
  output logic                                degenerate
);

  localparam int C   = COORD_BITS;
  localparam int F   = NORMAL_FRAC_BITS;
  localparam int PB  = vnsn_pkg::POS_BITS;
  localparam int OB  = vnsn_pkg::OUT_BITS;
  localparam int PW  = 3 * C;
  localparam int D   = C + 1;
  localparam int PRW = 2 * D;
  localparam int CW  = PRW + 1;
  localparam int SW  = CW + 3;
  localparam int R   = vnsn_pkg::REDUCE_BITS;
  localparam int KW  = $clog2(SW + 1);
  localparam int QW  = 2 * R + 2;
  localparam int RW  = vnsn_pkg::ROOT_BITS;
  localparam int XB  = 2 * vnsn_pkg::SQRT_EXTRA;
  localparam int QB  = F + 2;
  localparam int NW  = R + F + 7;
  localparam int SBW = 3 * R + 4;
  localparam int EW  = F + OB + 2;

  // Stage positions along the pipeline.
  localparam int ST_DIFF  = 0;
  localparam int ST_PROD  = 1;
  localparam int ST_CROSS = 2;
  localparam int ST_SUM   = 3;
  localparam int ST_MAG   = 4;
  localparam int ST_RED   = 5;
  localparam int ST_SQ    = 6;
  localparam int ST_Q     = 7;
  localparam int ST_SQRT  = 8;
  localparam int ST_NUM   = ST_SQRT + RW;
  localparam int ST_DIV   = ST_NUM + 1;
  localparam int ST_OUT   = ST_DIV + QB;
  localparam int NS       = ST_OUT + 1;

  localparam logic [QB-1:0] UNIT   = {2'b01, {F{1'b0}}};
  localparam logic [EW-1:0] UNIT_W = EW'(UNIT);
  localparam logic [OB-1:0] UNIT16 = UNIT_W[OB-1:0];

  // Valid bits and stage enables.
  logic [NS-1:0] vld;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !vld[NS-1] || out_ready;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= in_valid;
      end
      for (int i = 1; i < NS; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NS-1];

  // Unpack the points: center first, then the ring in order.
  logic [PB-1:0]        pos_in [7];
  logic signed [C-1:0]  crd    [7][3];

  assign pos_in[0] = center_pos;
  assign pos_in[1] = right_pos;
  assign pos_in[2] = up_right_pos;
  assign pos_in[3] = up_pos;
  assign pos_in[4] = left_pos;
  assign pos_in[5] = down_left_pos;
  assign pos_in[6] = down_pos;

  for (genvar gp = 0; gp < 7; gp++) begin : g_unpack
    logic [PW+PB-1:0] wide;
    assign wide = {{PW{1'b0}}, pos_in[gp]};
    for (genvar gj = 0; gj < 3; gj++) begin : g_axis
      assign crd[gp][gj] = wide[(2-gj)*C +: C];
    end
  end

  // Neighbour differences.
  logic signed [D-1:0] dif [6][3];

  always_ff @(posedge clk) begin
    if (en[ST_DIFF]) begin
      for (int n = 0; n < 6; n++) begin
        for (int j = 0; j < 3; j++) begin
          dif[n][j] <= {crd[n+1][j][C-1], crd[n+1][j]} - {crd[0][j][C-1], crd[0][j]};
        end
      end
    end
  end

  // Partial products of next x current for each ring pair.
  logic signed [PRW-1:0] prd [6][6];

  always_ff @(posedge clk) begin
    if (en[ST_PROD]) begin
      for (int i = 0; i < 6; i++) begin
        prd[i][0] <= dif[(i+1)%6][1] * dif[i][2];
        prd[i][1] <= dif[(i+1)%6][2] * dif[i][1];
        prd[i][2] <= dif[(i+1)%6][2] * dif[i][0];
        prd[i][3] <= dif[(i+1)%6][0] * dif[i][2];
        prd[i][4] <= dif[(i+1)%6][0] * dif[i][1];
        prd[i][5] <= dif[(i+1)%6][1] * dif[i][0];
      end
    end
  end

  // Cross product components.
  logic signed [CW-1:0] crs [6][3];

  always_ff @(posedge clk) begin
    if (en[ST_CROSS]) begin
      for (int i = 0; i < 6; i++) begin
        for (int j = 0; j < 3; j++) begin
          crs[i][j] <= CW'(prd[i][2*j]) - CW'(prd[i][2*j+1]);
        end
      end
    end
  end

  // Sum of the six cross products.
  logic signed [SW-1:0] sm [3];
  logic signed [SW-1:0] sm_next [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sm_next[j] = '0;
      for (int i = 0; i < 6; i++) begin
        sm_next[j] = sm_next[j] + SW'(crs[i][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_SUM]) begin
      sm <= sm_next;
    end
  end

  // Magnitudes, signs, zero detection and the combined magnitude bits.
  logic [SW-1:0] mag [3];
  logic [2:0]    sgn_m;
  logic          zero_m;
  logic [SW-1:0] orv;

  always_ff @(posedge clk) begin
    if (en[ST_MAG]) begin
      for (int j = 0; j < 3; j++) begin
        mag[j]   <= sm[j][SW-1] ? SW'(-sm[j]) : SW'(sm[j]);
        sgn_m[j] <= sm[j][SW-1];
      end
      zero_m <= (sm[0] == '0) && (sm[1] == '0) && (sm[2] == '0);
      orv    <= (sm[0][SW-1] ? SW'(-sm[0]) : SW'(sm[0]))
              | (sm[1][SW-1] ? SW'(-sm[1]) : SW'(sm[1]))
              | (sm[2][SW-1] ? SW'(-sm[2]) : SW'(sm[2]));
    end
  end

  // Reduce every magnitude by the shift that brings the largest under 2^R.
  logic [KW-1:0]      kshift;
  logic [2:0][R-1:0]  mr;
  logic [2:0]         sgn_r;
  logic               zero_r;

  always_comb begin
    kshift = '0;
    for (int b = R; b < SW; b++) begin
      if (orv[b]) begin
        kshift = KW'(b - R + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_RED]) begin
      for (int j = 0; j < 3; j++) begin
        mr[j] <= R'(mag[j] >> kshift);
      end
      sgn_r  <= sgn_m;
      zero_r <= zero_m;
    end
  end

  // Squares of the reduced magnitudes.
  logic [2*R-1:0]    sq [3];
  logic [2:0][R-1:0] mr_s;
  logic [2:0]        sgn_s;
  logic              zero_s;

  always_ff @(posedge clk) begin
    if (en[ST_SQ]) begin
      for (int j = 0; j < 3; j++) begin
        sq[j] <= mr[j] * mr[j];
      end
      mr_s   <= mr;
      sgn_s  <= sgn_r;
      zero_s <= zero_r;
    end
  end

  // Sum of squares, scaled for the extra root fraction bits.
  logic [2*RW-1:0] rad;
  logic [SBW-1:0]  sb_q;
  logic [QW-1:0]   qsum;

  assign qsum = QW'(sq[0]) + QW'(sq[1]) + QW'(sq[2]);

  always_ff @(posedge clk) begin
    if (en[ST_Q]) begin
      rad  <= {qsum, {XB{1'b0}}};
      sb_q <= {mr_s, sgn_s, zero_s};
    end
  end

  // Square root of the scaled sum of squares.
  logic [RW-1:0]     root;
  logic [SBW-1:0]    sb_rt;
  logic [2:0][R-1:0] mr_t;
  logic [2:0]        sgn_t;
  logic              zero_t;

  vnsn_sqrt #(
    .RW  (RW),
    .SBW (SBW)
  ) u_sqrt (
    .clk    (clk),
    .en     (en[ST_SQRT +: RW]),
    .rad    (rad),
    .sb_in  (sb_q),
    .root   (root),
    .sb_out (sb_rt)
  );

  assign {mr_t, sgn_t, zero_t} = sb_rt;

  // Rounded dividends and the divisor.
  logic [RW-1:0]      sdiv;
  logic [2:0][NW-1:0] num;
  logic [RW-1:0]      dvs;
  logic [3:0]         sb_n;

  assign sdiv = (root == '0) ? RW'(1) : root;

  always_ff @(posedge clk) begin
    if (en[ST_NUM]) begin
      for (int j = 0; j < 3; j++) begin
        num[j] <= NW'({mr_t[j], {(F + vnsn_pkg::SQRT_EXTRA){1'b0}}}) + NW'(sdiv >> 1);
      end
      dvs  <= sdiv;
      sb_n <= {sgn_t, zero_t};
    end
  end

  // Divide each component by the root.
  logic [2:0][QB-1:0] quo;
  logic [3:0]         sb_d;
  logic [2:0]         sgn_d;
  logic               zero_d;

  vnsn_div #(
    .QB  (QB),
    .NW  (NW),
    .RW  (RW),
    .SBW (4)
  ) u_div (
    .clk    (clk),
    .en     (en[ST_DIV +: QB]),
    .num    (num),
    .dvs    (dvs),
    .sb_in  (sb_n),
    .quo    (quo),
    .sb_out (sb_d)
  );

  assign {sgn_d, zero_d} = sb_d;

  // Saturate, apply the x and z signs, fix up y and handle the zero sum.
  logic [QB-1:0] sat [3];
  logic [EW-1:0] ext [3];
  logic [OB-1:0] nx_next;
  logic [OB-1:0] ny_next;
  logic [OB-1:0] nz_next;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sat[j] = (quo[j] > UNIT) ? UNIT : quo[j];
      ext[j] = EW'(sat[j]);
    end
    if (zero_d) begin
      nx_next = '0;
      ny_next = UNIT16;
      nz_next = '0;
    end else begin
      nx_next = sgn_d[0] ? OB'(~ext[0] + EW'(1)) : OB'(ext[0]);
      ny_next = (sat[1] == '0) ? UNIT16 : OB'(ext[1]);
      nz_next = sgn_d[2] ? OB'(~ext[2] + EW'(1)) : OB'(ext[2]);
    end
  end

  // Sign bits are indexed like the components: sgn_d[0] is x, sgn_d[2] is z.
  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      normal_x   <= nx_next;
      normal_y   <= ny_next;
      normal_z   <= nz_next;
      degenerate <= zero_d;
    end
  end

  // A degenerate result is always the up vector.
  `VNSN_ASSERT_IMPL(a_degen_up, out_valid && degenerate, normal_x == '0 && normal_z == '0 && normal_y == UNIT16, "degenerate result is not the up vector")

  // The y component is never left at zero.
  `VNSN_ASSERT_IMPL(a_y_nonzero, (F < OB) && out_valid, normal_y != '0, "normal_y is zero")

endmodule
